/* sv/websocket_client_frame_parser_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the WebSocket client frame parser.
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis. The using module must have clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_CLIENT_FRAME_PARSER_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Plain property that must hold at every clock edge out of reset.
`define WSCFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define WSCFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define WSCFP_ASSERT(label, prop, msg)
`define WSCFP_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

/* sv/wscfp_pkg.sv */
// ---------------------------------------------------------------------------
// wscfp_pkg
// Types and constants shared by the WebSocket client frame parser.
// ---------------------------------------------------------------------------
package wscfp_pkg;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INCOMPLETE = 2'd1;
	localparam logic [1:0] ST_PROTOCOL   = 2'd2;
	localparam logic [1:0] ST_TOO_LARGE  = 2'd3;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [15:0] LIMIT_RESET = 16'd4096;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       buffer_end;
	} wscfp_item_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        data_valid;
		logic        frame_end;
		logic [1:0]  status;
		logic [3:0]  frame_opcode;
		logic [15:0] payload_length;
		logic [16:0] frame_length;
	} wscfp_result_t;

endpackage

/* sv/wscfp_in_if.sv */
// ---------------------------------------------------------------------------
// wscfp_in_if
// Byte channel into the frame parser: one stream byte per word.
// ---------------------------------------------------------------------------
interface wscfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       buffer_end;

	modport source (output valid, output in_byte, output buffer_end, input ready);
	modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

/* sv/wscfp_out_if.sv */
// ---------------------------------------------------------------------------
// wscfp_out_if
// Result channel out of the frame parser: payload byte and frame status.
// ---------------------------------------------------------------------------
interface wscfp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        data_valid;
	logic        frame_end;
	logic [1:0]  status;
	logic [3:0]  frame_opcode;
	logic [15:0] payload_length;
	logic [16:0] frame_length;

	modport source (
		output valid, output data_byte, output data_valid, output frame_end,
		output status, output frame_opcode, output payload_length,
		output frame_length, input ready
	);
	modport sink (
		input valid, input data_byte, input data_valid, input frame_end,
		input status, input frame_opcode, input payload_length,
		input frame_length, output ready
	);
endinterface

/* sv/wscfp_step.sv */
// ---------------------------------------------------------------------------
// wscfp_step
// Per-byte header state machine, mask key store and payload unmasking.
// ---------------------------------------------------------------------------
`include "websocket_client_frame_parser_assert.svh"

module wscfp_step (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [15:0]             cfg_wdata,
	input  logic                    fire,
	input  wscfp_pkg::wscfp_item_t  item,
	output logic                    res_valid,
	output wscfp_pkg::wscfp_result_t res
);
	import wscfp_pkg::*;

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXT_HI  = 3'd2;
	localparam logic [2:0] PH_EXT_LO  = 3'd3;
	localparam logic [2:0] PH_MASK    = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_DISCARD = 3'd6;

	logic [15:0] limit_q;
	logic [2:0]  phase_q,  phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic [15:0] length_q, length_d;
	logic [31:0] mask_q,   mask_d;
	logic [15:0] count_q,  count_d;
	logic        ext_q,    ext_d;

	logic [7:0]  b;
	logic        last;
	logic [6:0]  code;
	logic [15:0] count_inc;
	logic [7:0]  key;
	logic [7:0]  plain;
	logic        do_accept;
	logic        op_known;

	assign b         = item.in_byte;
	assign last      = item.buffer_end;
	assign code      = b[6:0];
	assign count_inc = count_q + 16'd1;
	assign op_known  = (b[3:0] == OP_TEXT) || (b[3:0] == OP_CLOSE) ||
		(b[3:0] == OP_PING) || (b[3:0] == OP_PONG);

	always_comb begin
		unique case (count_q[1:0])
			2'd0: key = mask_q[31:24];
			2'd1: key = mask_q[23:16];
			2'd2: key = mask_q[15:8];
			default: key = mask_q[7:0];
		endcase
	end
	assign plain = b ^ key;

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		length_d  = length_q;
		mask_d    = mask_q;
		count_d   = count_q;
		ext_d     = ext_q;
		do_accept = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		unique case (phase_q)
			PH_HDR1: begin
				if (!b[7] || (opcode_q[3] && code >= 7'd126)) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_PROTOCOL;
					phase_d       = last ? PH_HDR0 : PH_DISCARD;
				end else if (code == 7'd127) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_TOO_LARGE;
					phase_d       = last ? PH_HDR0 : PH_DISCARD;
				end else if (code == 7'd126) begin
					ext_d   = 1'b1;
					phase_d = PH_EXT_HI;
					if (last) begin
						res_valid     = 1'b1;
						res.frame_end = 1'b1;
						res.status    = ST_INCOMPLETE;
						phase_d       = PH_HDR0;
					end
				end else begin
					ext_d     = 1'b0;
					length_d  = {9'd0, code};
					do_accept = 1'b1;
				end
			end
			PH_EXT_HI: begin
				length_d = {b, 8'd0};
				phase_d  = PH_EXT_LO;
				if (last) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_INCOMPLETE;
					phase_d       = PH_HDR0;
				end
			end
			PH_EXT_LO: begin
				length_d = {length_q[15:8], length_q[7:0] | b};
				if (length_d < 16'd126) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_PROTOCOL;
					phase_d       = last ? PH_HDR0 : PH_DISCARD;
				end else begin
					do_accept = 1'b1;
				end
			end
			PH_MASK: begin
				mask_d  = {mask_q[23:0], b};
				count_d = count_inc;
				if (count_inc >= 16'd4) begin
					count_d = '0;
					phase_d = PH_PAYLOAD;
				end
				if (count_inc >= 16'd4 && length_q == 16'd0) begin
					// Empty payload: the frame closes on its last mask byte.
					res_valid          = 1'b1;
					res.frame_end      = 1'b1;
					res.status         = ST_OK;
					res.frame_opcode   = opcode_q;
					res.payload_length = length_q;
					res.frame_length   = {1'b0, length_q} + (ext_q ? 17'd8 : 17'd6);
					phase_d            = PH_HDR0;
				end else if (last) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_INCOMPLETE;
					phase_d       = PH_HDR0;
				end
			end
			PH_PAYLOAD: begin
				count_d        = count_inc;
				res_valid      = 1'b1;
				res.data_byte  = plain;
				res.data_valid = 1'b1;
				if (count_inc == length_q) begin
					res.frame_end      = 1'b1;
					res.status         = ST_OK;
					res.frame_opcode   = opcode_q;
					res.payload_length = length_q;
					res.frame_length   = {1'b0, length_q} + (ext_q ? 17'd8 : 17'd6);
					phase_d            = PH_HDR0;
				end else if (last) begin
					res.frame_end = 1'b1;
					res.status    = ST_INCOMPLETE;
					phase_d       = PH_HDR0;
				end
			end
			PH_DISCARD: begin
				if (last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				// First header byte; the unused phase code lands here too.
				phase_d = PH_HDR0;
				if (last) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_INCOMPLETE;
				end else if (!b[7] || b[6:4] != 3'd0 || !op_known) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_PROTOCOL;
					phase_d       = PH_DISCARD;
				end else begin
					opcode_d = b[3:0];
					phase_d  = PH_HDR1;
				end
			end
		endcase

		// Shared length checks once the full payload length is known.
		if (do_accept) begin
			if (opcode_q == OP_CLOSE && length_d == 16'd1) begin
				res_valid     = 1'b1;
				res.frame_end = 1'b1;
				res.status    = ST_PROTOCOL;
				phase_d       = last ? PH_HDR0 : PH_DISCARD;
			end else if (length_d > limit_q) begin
				res_valid     = 1'b1;
				res.frame_end = 1'b1;
				res.status    = ST_TOO_LARGE;
				phase_d       = last ? PH_HDR0 : PH_DISCARD;
			end else begin
				phase_d = PH_MASK;
				count_d = '0;
				if (last) begin
					res_valid     = 1'b1;
					res.frame_end = 1'b1;
					res.status    = ST_INCOMPLETE;
					phase_d       = PH_HDR0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			length_q <= '0;
			mask_q   <= '0;
			count_q  <= '0;
			ext_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (fire) begin
				phase_q  <= phase_d;
				opcode_q <= opcode_d;
				length_q <= length_d;
				mask_q   <= mask_d;
				count_q  <= count_d;
				ext_q    <= ext_d;
			end
		end
	end

	`WSCFP_ASSERT_IMP(a_data_only_in_payload, res_valid && res.data_valid,
		phase_q == PH_PAYLOAD, "payload byte produced outside the payload phase")
	`WSCFP_ASSERT_IMP(a_status_needs_end, res_valid && res.status != ST_OK,
		res.frame_end, "nonzero status without frame end")
	`WSCFP_ASSERT_IMP(a_mask_count_range, phase_q == PH_MASK,
		count_q < 16'd4, "mask byte count out of range")
	`WSCFP_ASSERT_IMP(a_ok_has_opcode, res_valid && res.frame_end && res.status == ST_OK,
		res.frame_opcode == opcode_q && res.payload_length == length_q,
		"completed frame reports stale header fields")

endmodule

/* sv/wscfp_outbuf.sv */
// ---------------------------------------------------------------------------
// wscfp_outbuf
// Result register that drives the output channel and holds under stall.
// ---------------------------------------------------------------------------
module wscfp_outbuf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  wscfp_pkg::wscfp_result_t res,
	output logic                     space,
	wscfp_out_if.source              dst
);
	import wscfp_pkg::*;

	logic          valid_q;
	wscfp_result_t res_q;

	// The register can take a new word when empty or when the held one leaves.
	assign space = !valid_q || dst.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			res_q <= res;
		end
	end

	assign dst.valid          = valid_q;
	assign dst.data_byte      = res_q.data_byte;
	assign dst.data_valid     = res_q.data_valid;
	assign dst.frame_end      = res_q.frame_end;
	assign dst.status         = res_q.status;
	assign dst.frame_opcode   = res_q.frame_opcode;
	assign dst.payload_length = res_q.payload_length;
	assign dst.frame_length   = res_q.frame_length;

endmodule

/* sv/websocket_client_frame_parser.sv */
// ---------------------------------------------------------------------------
// websocket_client_frame_parser
// Client-to-server WebSocket frame parser with payload unmasking.
// ---------------------------------------------------------------------------
// The item channel carries one stream byte per word together with a
// buffer_end flag that marks the last byte currently available. The result
// channel carries one unmasked payload byte per word, and the last word of a
// frame or attempt has frame_end set with the status, opcode and lengths.
// Header bytes and mask bytes produce no result word unless they end an
// attempt. cfg_we writes payload_limit from cfg_wdata; write it only while
// the parser is idle.
// A byte passes an input register and then a result register on its way
// to the result channel. One byte is taken every cycle while no result
// word waits for the receiver. When the receiver stalls, the result
// register holds its word and the input register keeps accepting bytes
// that produce no result; a byte that does produce one waits in the input
// register. Reset clears all state, sets payload_limit to 4096 and expects
// a first header byte.
// ---------------------------------------------------------------------------
module websocket_client_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	wscfp_in_if.sink    item,
	wscfp_out_if.source result
);
	import wscfp_pkg::*;

	logic          valid_s1;
	wscfp_item_t   item_s1;
	logic          step_res_valid;
	wscfp_result_t step_res;
	logic          space;
	logic          advance;

	assign advance    = valid_s1 && (!step_res_valid || space);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.in_byte    <= item.in_byte;
			item_s1.buffer_end <= item.buffer_end;
		end
	end

	wscfp_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (advance),
		.item      (item_s1),
		.res_valid (step_res_valid),
		.res       (step_res)
	);

	wscfp_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && step_res_valid),
		.res    (step_res),
		.space  (space),
		.dst    (result)
	);

endmodule

/* dv/websocket_client_frame_parser_checker.sv */
// ---------------------------------------------------------------------------
// WebSocket client frame parser: result checker
// Watches the byte and result channels and the limit register port, keeps its
// own copy of the header state machine, and compares every result word field
// by field with the oldest predicted word. Counts the mismatches it finds.
// ---------------------------------------------------------------------------
module websocket_client_frame_parser_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	wscfp_in_if         item,
	wscfp_out_if        result,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import wscfp_pkg::*;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [15:0] EXT_MIN = 16'd126;

	typedef enum logic [2:0] {
		HDR_FIRST,
		HDR_LEN,
		EXT_HIGH,
		EXT_LOW,
		MASK_KEY,
		PAYLOAD,
		DISCARD
	} parse_phase_t;

	parse_phase_t  phase;
	logic [3:0]    opcode_q;
	logic [15:0]   length_q;
	logic [31:0]   key_q;
	logic [15:0]   count_q;
	logic          ext_q;
	logic [15:0]   limit_q;
	wscfp_result_t expected_words[$];

	// A failed check ends the attempt; without buffer_end the rest is dropped.
	function automatic wscfp_result_t reject(input logic [1:0] st, input logic last);
		wscfp_result_t w;
		w = '0;
		w.frame_end = 1'b1;
		w.status = st;
		phase = last ? HDR_FIRST : DISCARD;
		return w;
	endfunction

	function automatic wscfp_result_t cut_short(input logic [7:0] d, input logic dv);
		wscfp_result_t w;
		w = '0;
		w.data_byte = d;
		w.data_valid = dv;
		w.frame_end = 1'b1;
		w.status = ST_INCOMPLETE;
		phase = HDR_FIRST;
		return w;
	endfunction

	function automatic wscfp_result_t complete(input logic [7:0] d, input logic dv);
		wscfp_result_t w;
		w = '0;
		w.data_byte = d;
		w.data_valid = dv;
		w.frame_end = 1'b1;
		w.status = ST_OK;
		w.frame_opcode = opcode_q;
		w.payload_length = length_q;
		w.frame_length = (ext_q ? 17'd4 : 17'd2) + 17'd4 + {1'b0, length_q};
		phase = HDR_FIRST;
		return w;
	endfunction

	function automatic bit judge_length(input logic last, output wscfp_result_t w);
		w = '0;
		if (opcode_q == OP_CLOSE && length_q == 16'd1) begin
			w = reject(ST_PROTOCOL, last);
			return 1'b1;
		end
		if (length_q > limit_q) begin
			w = reject(ST_TOO_LARGE, last);
			return 1'b1;
		end
		phase = MASK_KEY;
		count_q = '0;
		if (last) begin
			w = cut_short(8'd0, 1'b0);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the parser by one stream byte; returns 1 when a word is due.
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output wscfp_result_t w);
		logic [7:0] key;
		logic [7:0] d;
		w = '0;
		case (phase)
			HDR_LEN: begin
				if (!b[7] || (opcode_q >= OP_CLOSE && b[6:0] >= LEN_EXT16)) begin
					w = reject(ST_PROTOCOL, last);
					return 1'b1;
				end
				if (b[6:0] == LEN_EXT64) begin
					w = reject(ST_TOO_LARGE, last);
					return 1'b1;
				end
				if (b[6:0] == LEN_EXT16) begin
					ext_q = 1'b1;
					phase = EXT_HIGH;
					if (last) begin
						w = cut_short(8'd0, 1'b0);
						return 1'b1;
					end
					return 1'b0;
				end
				ext_q = 1'b0;
				length_q = {9'd0, b[6:0]};
				return judge_length(last, w);
			end
			EXT_HIGH: begin
				length_q = {b, 8'd0};
				phase = EXT_LOW;
				if (last) begin
					w = cut_short(8'd0, 1'b0);
					return 1'b1;
				end
				return 1'b0;
			end
			EXT_LOW: begin
				length_q[7:0] = b;
				if (length_q < EXT_MIN) begin
					w = reject(ST_PROTOCOL, last);
					return 1'b1;
				end
				return judge_length(last, w);
			end
			MASK_KEY: begin
				key_q = {key_q[23:0], b};
				count_q = count_q + 16'd1;
				if (count_q >= 16'd4) begin
					count_q = '0;
					if (length_q == 16'd0) begin
						w = complete(8'd0, 1'b0);
						return 1'b1;
					end
					phase = PAYLOAD;
				end
				if (last) begin
					w = cut_short(8'd0, 1'b0);
					return 1'b1;
				end
				return 1'b0;
			end
			PAYLOAD: begin
				key = key_q[8 * (3 - count_q[1:0]) +: 8];
				d = b ^ key;
				count_q = count_q + 16'd1;
				if (count_q == length_q)
					w = complete(d, 1'b1);
				else if (last)
					w = cut_short(d, 1'b1);
				else begin
					w.data_byte = d;
					w.data_valid = 1'b1;
				end
				return 1'b1;
			end
			DISCARD: begin
				if (last)
					phase = HDR_FIRST;
				return 1'b0;
			end
			default: begin
				phase = HDR_FIRST;
				if (last) begin
					w = cut_short(8'd0, 1'b0);
					return 1'b1;
				end
				if (!b[7] || b[6:4] != 3'd0
						|| !(b[3:0] inside {OP_TEXT, OP_CLOSE, OP_PING, OP_PONG})) begin
					w = reject(ST_PROTOCOL, last);
					return 1'b1;
				end
				opcode_q = b[3:0];
				phase = HDR_LEN;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wscfp_result_t w;
		wscfp_result_t want;
		int errs;
		if (!arst_n) begin
			phase = HDR_FIRST;
			opcode_q = '0;
			length_q = '0;
			key_q = '0;
			count_q = '0;
			ext_q = 1'b0;
			limit_q = LIMIT_RESET;
			expected_words.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (cfg_we)
				limit_q = cfg_wdata;
			if (result.valid && result.ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: data_byte %0d frame_end %0d status %0d",
						result.data_byte, result.frame_end, result.status);
					errs++;
				end else begin
					want = expected_words.pop_front();
					errs += field_diff("data_byte", want.data_byte, result.data_byte);
					errs += field_diff("data_valid", want.data_valid, result.data_valid);
					errs += field_diff("frame_end", want.frame_end, result.frame_end);
					errs += field_diff("status", want.status, result.status);
					errs += field_diff("frame_opcode", want.frame_opcode, result.frame_opcode);
					errs += field_diff("payload_length", want.payload_length,
						result.payload_length);
					errs += field_diff("frame_length", want.frame_length, result.frame_length);
				end
			end
			if (item.valid && item.ready) begin
				if (parse_byte(item.in_byte, item.buffer_end, w))
					expected_words.push_back(w);
			end
			mismatches <= mismatches + errs;
			outstanding <= expected_words.size();
		end
	end

endmodule

/* dv/websocket_client_frame_parser_test.sv */
// ---------------------------------------------------------------------------
// WebSocket client frame parser testbench
// Drives a byte stream of valid frames, truncated frames, corrupted headers
// and noise through the parser under several payload limits and handshake
// gap patterns; a separate checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module websocket_client_frame_parser_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wscfp_pkg::*;

	localparam int RANDOM_BYTES = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT = 2000;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          mismatches;
	int          outstanding;
	int          bytes_sent;
	int          send_gap_pct;
	int          recv_gap_pct;
	int          quiet_cycles;
	logic [15:0] limit_now;
	logic [15:0] limits[7];
	logic [7:0]  frame_q[$];

	wscfp_in_if  in_ch();
	wscfp_out_if out_ch();

	websocket_client_frame_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(in_ch),
		.result(out_ch)
	);

	websocket_client_frame_parser_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(in_ch),
		.result(out_ch),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Nothing accepted on either side for too long means the parser hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (bytes_sent < RANDOM_BYTES / 3) begin
			send_gap_pct = 30;
			recv_gap_pct = 48;
		end else if (bytes_sent < 2 * RANDOM_BYTES / 3) begin
			send_gap_pct = 48;
			recv_gap_pct = 30;
		end else begin
			send_gap_pct = 0;
			recv_gap_pct = 0;
		end
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.buffer_end <= last;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	// Header, masking key and random masked payload of one client frame.
	function automatic void build_frame(input logic [3:0] op, input int unsigned len,
			input bit ext);
		frame_q.delete();
		frame_q.push_back({1'b1, 3'b000, op});
		if (ext) begin
			frame_q.push_back({1'b1, LEN_EXT16});
			frame_q.push_back(len[15:8]);
			frame_q.push_back(len[7:0]);
		end else begin
			frame_q.push_back({1'b1, len[6:0]});
		end
		repeat (4 + len) frame_q.push_back(8'($urandom));
	endfunction

	task automatic send_frame(input int stop, input logic end_last);
		for (int i = 0; i <= stop; i++)
			send_byte(frame_q[i], (i == stop) ? end_last : 1'b0);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_sequence();
		logic [3:0]  op;
		logic [3:0]  bad_op;
		int unsigned len;
		bit          ext;
		bit          refused;
		int          kind;
		int          n;
		kind = $urandom_range(99);
		ext = 1'b0;
		if ($urandom_range(1) == 0) begin
			op = OP_TEXT;
		end else begin
			case ($urandom_range(2))
				0: op = OP_CLOSE;
				1: op = OP_PING;
				default: op = OP_PONG;
			endcase
		end
		if (op >= OP_CLOSE)
			len = ($urandom_range(3) == 0) ? $urandom_range(21, 125) : $urandom_range(0, 20);
		else if ($urandom_range(9) < 6)
			len = $urandom_range(0, 20);
		else if ($urandom_range(3) != 0)
			len = $urandom_range(21, 125);
		else begin
			len = $urandom_range(126, 300);
			ext = 1'b1;
		end
		refused = (op == OP_CLOSE && len == 1) || len > limit_now;
		build_frame(op, len, ext);
		if (kind < 60) begin
			send_frame(frame_q.size() - 1, refused ? 1'b1 : ($urandom_range(3) == 0));
		end else if (kind < 70) begin
			send_frame($urandom_range(0, frame_q.size() - 1), 1'b1);
		end else if (kind < 85) begin
			case ($urandom_range(7))
				0: frame_q[0][7] = 1'b0;
				1: frame_q[0][6:4] = 3'($urandom_range(1, 7));
				2: begin
					do bad_op = 4'($urandom_range(15));
					while (bad_op inside {OP_TEXT, OP_CLOSE, OP_PING, OP_PONG});
					frame_q[0][3:0] = bad_op;
				end
				3: frame_q[1][7] = 1'b0;
				4: frame_q[1][6:0] = LEN_EXT64;
				5: begin
					build_frame(($urandom_range(1) == 0) ? OP_PING : OP_CLOSE, 0, 1'b0);
					frame_q[1][6:0] = ($urandom_range(1) == 0) ? LEN_EXT16 : LEN_EXT64;
				end
				6: build_frame(OP_TEXT, $urandom_range(0, 125), 1'b1);
				default: build_frame(OP_CLOSE, 1, 1'b0);
			endcase
			if ($urandom_range(9) < 7)
				send_frame(frame_q.size() - 1, 1'b1);
			else
				send_frame($urandom_range(0, frame_q.size() - 1), 1'b1);
		end else begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				send_byte(8'($urandom), (i == n - 1) ? 1'b1 : ($urandom_range(4) == 0));
		end
	endtask

	task automatic write_limit(input logic [15:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_now = value;
	endtask

	initial begin
		int base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.buffer_end = 1'b0;
		bytes_sent = 0;
		quiet_cycles = 0;
		send_gap_pct = 30;
		recv_gap_pct = 48;
		limit_now = LIMIT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A buffer end on the first header byte is always reported incomplete.
		send_byte({1'b1, 3'b000, OP_TEXT}, 1'b1);
		// Zero-length frame ends on its last mask byte.
		build_frame(OP_TEXT, 0, 1'b0);
		send_frame(frame_q.size() - 1, 1'b0);
		// Payload bytes at both extremes under an all-ones key.
		build_frame(OP_PING, 2, 1'b0);
		for (int i = 2; i < 6; i++)
			frame_q[i] = 8'hFF;
		frame_q[6] = 8'h00;
		frame_q[7] = 8'hFF;
		send_frame(frame_q.size() - 1, 1'b0);
		// One-byte close payload, rejected on a byte that also ends the buffer.
		send_byte({1'b1, 3'b000, OP_CLOSE}, 1'b0);
		send_byte(8'h81, 1'b1);
		// FIN clear, then dropped bytes until the buffer end.
		send_byte({1'b0, 3'b000, OP_TEXT}, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		// RSV bits set.
		send_byte({1'b1, 3'b111, OP_TEXT}, 1'b0);
		send_byte(8'h00, 1'b1);
		// Unknown opcode.
		send_byte(8'h82, 1'b0);
		send_byte(8'hFF, 1'b1);
		// Control frame with a 16-bit length code.
		send_byte({1'b1, 3'b000, OP_PONG}, 1'b0);
		send_byte({1'b1, LEN_EXT16}, 1'b1);
		// 64-bit length on a data frame is too large.
		send_byte({1'b1, 3'b000, OP_TEXT}, 1'b0);
		send_byte({1'b1, LEN_EXT64}, 1'b0);
		send_byte(8'h12, 1'b1);
		// Extended length below 126.
		build_frame(OP_TEXT, 125, 1'b1);
		send_frame(3, 1'b1);
		// Largest extended length exceeds the limit.
		build_frame(OP_TEXT, 0, 1'b1);
		frame_q[2] = 8'hFF;
		frame_q[3] = 8'hFF;
		send_frame(3, 1'b1);
		// Mask bit missing.
		send_byte({1'b1, 3'b000, OP_TEXT}, 1'b0);
		send_byte(8'h05, 1'b1);

		limits[0] = LIMIT_RESET;
		limits[1] = 16'd0;
		limits[2] = 16'hFFFF;
		limits[3] = 16'd125;
		limits[4] = 16'($urandom_range(126, 400));
		limits[5] = 16'($urandom);
		limits[6] = LIMIT_RESET;
		base = bytes_sent;
		for (int p = 0; p < 7; p++) begin
			if (p != 0)
				write_limit(limits[p]);
			while (bytes_sent < base + (p + 1) * RANDOM_BYTES / 7)
				random_sequence();
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
